FILE: design/cnb_pkg.sv
// Package for the categorical naive Bayes classifier.
// Holds the sequencer state type, the fixed-point constants and the op codes; no dependencies.
package cnb_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_TRAIN,
    ST_RD,
    ST_DIV,
    ST_MUL,
    ST_NEXT,
    ST_CMP,
    ST_OUT
  } state_t;

  localparam int unsigned PROD_W   = 17;
  localparam int unsigned FRAC_W   = 16;
  localparam logic [PROD_W-1:0] Q_ONE    = 17'h10000;
  localparam logic [PROD_W-1:0] PROD_MAX = 17'h1FFFF;

  localparam logic OP_TRAIN = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

FILE: design/cnb_div.sv
// Restoring divider, one quotient bit per cycle, for the count / rows factor.
// Depends on cnb_pkg for the product width and saturation value.
module cnb_div #(
  parameter int unsigned CW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [CW-1:0]               numer,
  input  logic [CW-1:0]               denom,
  output logic                        done,
  output logic [cnb_pkg::PROD_W-1:0]  quot
);
  localparam int unsigned NW = CW + cnb_pkg::FRAC_W;
  localparam int unsigned SW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [CW:0]   rem;
  logic [CW-1:0] den;
  logic [SW-1:0] steps;
  logic          busy;
  logic [CW:0]   trial;
  logic [CW:0]   shifted;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem[CW-1:0], q[NW-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(NW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= {numer, {cnb_pkg::FRAC_W{1'b0}}};
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      if (!trial[CW]) begin
        rem <= trial;
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

  // Saturate the quotient to the product range; a zero divisor gives zero.
  always_comb begin
    if (den == '0) begin
      quot = '0;
    end else if (q[NW-1:cnb_pkg::PROD_W] != '0) begin
      quot = cnb_pkg::PROD_MAX;
    end else begin
      quot = q[cnb_pkg::PROD_W-1:0];
    end
  end
endmodule

FILE: design/categorical_naive_bayes.sv
// Categorical naive Bayes classifier, top level.
// A training beat is accepted, its count read and then written back. A query beat walks the
// classes: each trained class has its count read, divided on the shared divider and multiplied
// in; an untrained class is skipped. The final query beat adds a compare pass and an output step.
// One beat at a time; a result waiting in the output register only holds a later query end.
// After reset a clearing pass zeroes all counts, one per cycle, before the first beat.
module categorical_naive_bayes #(
  parameter int unsigned NUM_CLASSES = 8,
  parameter int unsigned NUM_COLUMNS = 8,
  parameter int unsigned NUM_BINS    = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: class_label[2:0], column[5:3], bin[9:6], zero fill.
  input  logic [15:0] s_tdata,
  // op
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: predicted_class[2:0], found[3], zero fill.
  output logic [7:0]  m_tdata
);
  localparam int unsigned CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned DEPTH = NUM_CLASSES * NUM_COLUMNS * NUM_BINS;
  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned PW  = cnb_pkg::PROD_W;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  cnb_pkg::state_t state, state_next;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [AW-1:0]          addr;
  logic [AW:0]            clr_cnt;

  logic [PW-1:0]          prod [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] seen;
  logic [COUNT_WIDTH-1:0] rows;

  // Latched beat.
  logic [2:0] b_cls, b_col;
  logic [3:0] b_bin;
  logic       b_last;
  logic       b_ok;
  logic [CLW:0] cidx;

  logic          div_start, div_done;
  logic [PW-1:0] factor;
  logic [PW+PW-1:0] mul;

  logic          any;
  logic [CLW-1:0] best;
  logic [PW-1:0] best_val;
  logic [7:0]    out_data;
  logic          out_load;

  wire s_fire = s_tvalid && s_tready;
  wire cls_ok = ({29'd0, s_tdata[2:0]} < NUM_CLASSES);
  wire [CLW-1:0] cur = cidx[CLW-1:0];

  assign s_tready = (state == cnb_pkg::ST_IDLE);

  // The output register takes a new result once the previous one is gone or leaving.
  assign out_load = (state == cnb_pkg::ST_OUT) && (!m_tvalid || m_tready);

  // Table address from the clear counter (clearing pass), the latched beat (training) or the walking class.
  always_comb begin
    if (state == cnb_pkg::ST_CLR) begin
      addr = clr_cnt[AW-1:0];
    end else if (state == cnb_pkg::ST_TRAIN || (state == cnb_pkg::ST_RD && cidx[CLW])) begin
      addr = AW'((32'(b_cls) * NUM_COLUMNS + 32'(b_col)) * NUM_BINS + 32'(b_bin));
    end else begin
      addr = AW'((32'(cur) * NUM_COLUMNS + 32'(b_col)) * NUM_BINS + 32'(b_bin));
    end
  end

  // Count memory: one port, registered read.
  always_ff @(posedge clk) begin
    if (state == cnb_pkg::ST_CLR) begin
      mem[addr] <= '0;
    end else if (state == cnb_pkg::ST_TRAIN && b_ok && (rd_data != CMAX)) begin
      mem[addr] <= rd_data + 1'b1;
    end
    rd_data <= mem[addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      cnb_pkg::ST_CLR: begin
        if (clr_cnt == (AW+1)'(DEPTH - 1)) state_next = cnb_pkg::ST_IDLE;
      end
      cnb_pkg::ST_IDLE: begin
        if (s_fire) begin
          if (s_tuser == cnb_pkg::OP_QUERY) state_next = cnb_pkg::ST_NEXT;
          else if (cls_ok) state_next = cnb_pkg::ST_RD;
        end
      end
      // ST_RD waits for read data; training then writes back in ST_TRAIN, a query starts the divider.
      cnb_pkg::ST_RD: begin
        state_next = (cidx[CLW] == 1'b1) ? cnb_pkg::ST_TRAIN : cnb_pkg::ST_DIV;
        if (cidx[CLW] == 1'b0) div_start = 1'b1;
      end
      cnb_pkg::ST_TRAIN: state_next = cnb_pkg::ST_IDLE;
      cnb_pkg::ST_DIV: begin
        if (div_done) state_next = cnb_pkg::ST_MUL;
      end
      cnb_pkg::ST_MUL: state_next = cnb_pkg::ST_NEXT;
      cnb_pkg::ST_NEXT: begin
        if (32'(cidx) >= NUM_CLASSES) begin
          state_next = b_last ? cnb_pkg::ST_CMP : cnb_pkg::ST_IDLE;
        end else if (seen[cur]) begin
          state_next = cnb_pkg::ST_RD;
        end
      end
      cnb_pkg::ST_CMP: begin
        if (32'(cidx) >= NUM_CLASSES - 1) state_next = cnb_pkg::ST_OUT;
      end
      cnb_pkg::ST_OUT: begin
        if (out_load) state_next = cnb_pkg::ST_IDLE;
      end
      default: state_next = cnb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cnb_pkg::ST_CLR;
    else     state <= state_next;
  end

  // Shared divider: count * 65536 / rows.
  cnb_div #(.CW(COUNT_WIDTH)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (b_ok ? rd_data : '0),
    .denom (rows),
    .done  (div_done),
    .quot  (factor)
  );

  assign mul = prod[cur] * factor;

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      seen     <= '0;
      rows     <= '0;
      m_tvalid <= 1'b0;
      cidx     <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) prod[i] <= cnb_pkg::Q_ONE;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        cnb_pkg::ST_CLR: clr_cnt <= clr_cnt + 1'b1;
        cnb_pkg::ST_IDLE: begin
          if (s_fire) begin
            b_cls  <= s_tdata[2:0];
            b_col  <= s_tdata[5:3];
            b_bin  <= s_tdata[9:6];
            b_last <= s_tlast;
            b_ok   <= ({29'd0, s_tdata[5:3]} < NUM_COLUMNS) &&
                      ({28'd0, s_tdata[9:6]} < NUM_BINS);
            if (s_tuser == cnb_pkg::OP_QUERY) begin
              cidx <= '0;
            end else if (cls_ok) begin
              cidx <= {1'b1, {CLW{1'b0}}};
              if (s_tlast) begin
                seen[CLW'(s_tdata[2:0])] <= 1'b1;
                if (rows != CMAX) rows <= rows + 1'b1;
              end
            end
          end
        end
        cnb_pkg::ST_MUL: begin
          if (mul[PW+PW-1:cnb_pkg::FRAC_W] > (PW+PW-cnb_pkg::FRAC_W)'(cnb_pkg::PROD_MAX))
            prod[cur] <= cnb_pkg::PROD_MAX;
          else
            prod[cur] <= mul[cnb_pkg::FRAC_W +: PW];
          cidx <= cidx + 1'b1;
        end
        cnb_pkg::ST_NEXT: begin
          if (32'(cidx) >= NUM_CLASSES) begin
            cidx <= '0;
            any <= 1'b0;
            best <= '0;
            best_val <= '0;
          end else if (!seen[cur]) begin
            cidx <= cidx + 1'b1;
          end
        end
        cnb_pkg::ST_CMP: begin
          if (seen[cur] && (!any || prod[cur] > best_val)) begin
            any <= 1'b1;
            best <= cur;
            best_val <= prod[cur];
          end
          cidx <= cidx + 1'b1;
        end
        cnb_pkg::ST_OUT: begin
          if (out_load) begin
            for (int i = 0; i < NUM_CLASSES; i++) prod[i] <= cnb_pkg::Q_ONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result beat, held until taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {4'd0, any, 3'(best)};
    end
  end
  assign m_tdata = out_data;

  // A waiting result keeps its data until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while waiting");
  // No beat is accepted during the clearing pass.
  a_clr_block: assert property (@(posedge clk) disable iff (rst)
    (state == cnb_pkg::ST_CLR) |-> !s_tready)
    else $error("ready during clearing pass");
  // Found implies a class has been trained.
  a_found: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> (seen != '0))
    else $error("found without trained class");
  // Divider finishes only while the sequencer waits for it.
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == cnb_pkg::ST_DIV))
    else $error("divider done outside wait");
endmodule
